// ----- src/midpoint_ellipse_points_defines.svh -----
// Assertion macros for the ellipse point generator controller.
`ifndef MIDPOINT_ELLIPSE_POINTS_DEFINES_SVH
`define MIDPOINT_ELLIPSE_POINTS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define MEP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MEP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define MEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/mep_pkg.sv -----
// Shared types and constants of the midpoint ellipse point generator.
package mep_pkg;

    // Field and register widths.
    localparam int RADIUS_W = 5;
    localparam int FIELD_W  = 10;
    localparam int STEP_W   = 6;
    localparam int SQ_W     = 2 * RADIUS_W;
    localparam int MUL_W    = 14;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int G_W      = 19;
    localparam int D_W      = PROD_W;
    localparam int SUM_W    = 18;
    localparam int COORD_BITS_DEFAULT = 11;

    // Result limit for one ellipse run.
    localparam int MAX_RESULTS = 64;
    localparam logic [STEP_W-1:0] CNT_LAST = STEP_W'(MAX_RESULTS - 1);

    // Configuration registers.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 1'b1;
    localparam logic [RADIUS_W-1:0] RADIUS_X_RESET = 5'd5;
    localparam logic [RADIUS_W-1:0] RADIUS_Y_RESET = 5'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_START  = 4'd1,
        OP_SQ_B   = 4'd2,
        OP_A2B    = 4'd3,
        OP_INIT   = 4'd4,
        OP_EMIT   = 4'd5,
        OP_STEP1  = 4'd6,
        OP_R2_SQ1 = 4'd7,
        OP_R2_M1  = 4'd8,
        OP_R2_SQ2 = 4'd9,
        OP_R2_M2  = 4'd10,
        OP_R2_M3  = 4'd11,
        OP_R2_FIN = 4'd12,
        OP_STEP2  = 4'd13
    } op_t;

    typedef struct packed {
        op_t  op;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic px_lt_py;
        logic ey_zero;
    } status_t;

endpackage

// ----- src/mep_in_if.sv -----
// Request channel carrying one ellipse center and shift.
interface mep_in_if import mep_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] center_x;
    logic [FIELD_W-1:0] center_y;
    logic [FIELD_W-1:0] shift_x;

    modport source (
        output valid, center_x, center_y, shift_x,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, shift_x,
        output ready
    );

endinterface

// ----- src/mep_out_if.sv -----
// Result channel carrying one set of four mirrored plot points.
interface mep_out_if import mep_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) ();

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_right;
    logic [COORD_BITS-1:0] x_left;
    logic [COORD_BITS-1:0] y_upper;
    logic [COORD_BITS-1:0] y_lower;
    logic                  last_point;

    modport source (
        output valid, x_right, x_left, y_upper, y_lower, last_point,
        input  ready
    );

    modport sink (
        input  valid, x_right, x_left, y_upper, y_lower, last_point,
        output ready
    );

endinterface

// ----- src/midpoint_ellipse_points.sv -----
// Top level of the midpoint ellipse point generator.
//
//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+-----------------------------------------------
//  ellipse   | in  | valid/ready       | center_x, center_y, shift_x
//  points    | out | valid/ready       | x_right, x_left, y_upper, y_lower, last_point
//  cfg       | in  | cfg_we, no ready  | cfg_index, cfg_data (radius_x, radius_y)
//
// One request yields n results, n up to radius_x + radius_y + 1 (at most 64).
// Setup runs through the accepting idle state, S_SQ_B, S_A2B and S_INIT; the first result
// then takes one output write, every later result one walk step and one output write, and
// the switch to region two runs S_R2_SQ1 to S_R2_FIN on the shared multiplier.
// A new request is taken once the last result sits in the output register.
// Reset returns the controller to idle and the radii to 5 and 2.
// A stalled output holds its result; the walk waits until the register is free.
module midpoint_ellipse_points import mep_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RADIUS_W-1:0]  cfg_data,
    mep_in_if.sink               ellipse,
    mep_out_if.source            points
);

    cmd_t    cmd;
    status_t status;

    // Controller.
    mep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ellipse.valid),
        .in_ready  (ellipse.ready),
        .out_valid (points.valid),
        .out_ready (points.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    mep_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .center_x   (ellipse.center_x),
        .center_y   (ellipse.center_y),
        .shift_x    (ellipse.shift_x),
        .cmd        (cmd),
        .status     (status),
        .x_right    (points.x_right),
        .x_left     (points.x_left),
        .y_upper    (points.y_upper),
        .y_lower    (points.y_lower),
        .last_point (points.last_point)
    );

endmodule

// ----- src/mep_datapath.sv -----
// Datapath: radius registers, shared multiplier, midpoint walk and output register.
module mep_datapath import mep_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [RADIUS_W-1:0]   cfg_data,
    input  logic [FIELD_W-1:0]    center_x,
    input  logic [FIELD_W-1:0]    center_y,
    input  logic [FIELD_W-1:0]    shift_x,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [COORD_BITS-1:0] x_right,
    output logic [COORD_BITS-1:0] x_left,
    output logic [COORD_BITS-1:0] y_upper,
    output logic [COORD_BITS-1:0] y_lower,
    output logic                  last_point
);

    localparam logic signed [SUM_W-1:0] COORD_HI = SUM_W'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] COORD_LO = ~COORD_HI;

    // Clamp a coordinate sum to the signed output range.
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > COORD_HI)
        begin
            c = COORD_HI;
        end
        else if (v < COORD_LO)
        begin
            c = COORD_LO;
        end
        else
        begin
            c = v;
        end
        return c[COORD_BITS-1:0];
    endfunction

    logic [RADIUS_W-1:0] radius_x_reg, radius_y_reg;

    logic [FIELD_W-1:0]      cx_reg, cx_next, cy_reg, cy_next, sh_reg, sh_next;
    logic [RADIUS_W-1:0]     b_reg, b_next;
    logic [SQ_W-1:0]         a2_reg, a2_next, b2_reg, b2_next;
    logic [STEP_W-1:0]       ex_reg, ex_next, ey_reg, ey_next;
    logic signed [G_W-1:0]   px_reg, px_next, py_reg, py_next;
    logic signed [D_W-1:0]   d_reg, d_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [MUL_W-1:0]        mul_a, mul_b;

    logic [COORD_BITS-1:0] x_right_reg, x_right_next, x_left_reg, x_left_next;
    logic [COORD_BITS-1:0] y_upper_reg, y_upper_next, y_lower_reg, y_lower_next;
    logic                  last_point_reg, last_point_next;

    // Shared terms of the walk recurrences.
    logic signed [G_W-1:0] b2_g, a2_g, px_inc, py_dec, prod_g;
    logic signed [D_W-1:0] b2_d, a2_d, px_inc_d, py_dec_d, prod_d;
    logic [STEP_W-1:0]     ey_m1;
    logic                  d_neg, d_pos;

    assign b2_g     = signed'({{(G_W - SQ_W - 1){1'b0}}, b2_reg, 1'b0});
    assign a2_g     = signed'({{(G_W - SQ_W - 1){1'b0}}, a2_reg, 1'b0});
    assign px_inc   = px_reg + b2_g;
    assign py_dec   = py_reg - a2_g;
    assign prod_g   = signed'(prod_reg[G_W-1:0]);
    assign b2_d     = signed'({{(D_W - SQ_W){1'b0}}, b2_reg});
    assign a2_d     = signed'({{(D_W - SQ_W){1'b0}}, a2_reg});
    assign px_inc_d = D_W'(px_inc);
    assign py_dec_d = D_W'(py_dec);
    assign prod_d   = signed'(prod_reg);
    assign ey_m1    = ey_reg - STEP_W'(1);
    assign d_neg    = d_reg[D_W-1];
    assign d_pos    = !d_reg[D_W-1] && (d_reg != '0);

    // Plot coordinates of the current step.
    logic signed [SUM_W-1:0] cx_s, cy_s, sh_s, ex_s, ey_s;

    assign cx_s = {{(SUM_W - FIELD_W){cx_reg[FIELD_W-1]}}, cx_reg};
    assign cy_s = {{(SUM_W - FIELD_W){cy_reg[FIELD_W-1]}}, cy_reg};
    assign sh_s = {{(SUM_W - FIELD_W){1'b0}}, sh_reg};
    assign ex_s = {{(SUM_W - STEP_W){1'b0}}, ex_reg};
    assign ey_s = {{(SUM_W - STEP_W){1'b0}}, ey_reg};

    // Status for the controller.
    assign status.px_lt_py = (px_reg < py_reg);
    assign status.ey_zero  = (ey_reg == '0);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_x_reg <= RADIUS_X_RESET;
            radius_y_reg <= RADIUS_Y_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS_X: radius_x_reg <= cfg_data;
                CFG_RADIUS_Y: radius_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Operation decode: operand selection and register updates.
    always_comb
    begin
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        sh_next         = sh_reg;
        b_next          = b_reg;
        a2_next         = a2_reg;
        b2_next         = b2_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        d_next          = d_reg;
        mul_a           = '0;
        mul_b           = '0;
        x_right_next    = x_right_reg;
        x_left_next     = x_left_reg;
        y_upper_next    = y_upper_reg;
        y_lower_next    = y_lower_reg;
        last_point_next = last_point_reg;
        case (cmd.op)
            OP_START:
            begin
                cx_next = center_x;
                cy_next = center_y;
                sh_next = shift_x;
                b_next  = radius_y_reg;
                ex_next = '0;
                ey_next = {{(STEP_W - RADIUS_W){1'b0}}, radius_y_reg};
                px_next = '0;
                mul_a   = MUL_W'(radius_x_reg);
                mul_b   = MUL_W'(radius_x_reg);
            end
            OP_SQ_B:
            begin
                a2_next = prod_reg[SQ_W-1:0];
                mul_a   = MUL_W'(b_reg);
                mul_b   = MUL_W'(b_reg);
            end
            OP_A2B:
            begin
                b2_next = prod_reg[SQ_W-1:0];
                mul_a   = MUL_W'(a2_reg);
                mul_b   = MUL_W'(b_reg);
            end
            OP_INIT:
            begin
                // Start value of region one: 4*b^2 - 4*a^2*b + a^2.
                py_next = prod_g <<< 1;
                d_next  = (b2_d <<< 2) - (prod_d <<< 2) + a2_d;
            end
            OP_EMIT:
            begin
                x_right_next    = sat_coord(cx_s + ex_s + sh_s);
                x_left_next     = sat_coord(cx_s - ex_s + sh_s);
                y_upper_next    = sat_coord(cy_s + ey_s);
                y_lower_next    = sat_coord(cy_s - ey_s);
                last_point_next = cmd.last;
            end
            OP_STEP1:
            begin
                ex_next = ex_reg + STEP_W'(1);
                px_next = px_inc;
                if (d_neg)
                begin
                    d_next = d_reg + ((b2_d + px_inc_d) <<< 2);
                end
                else
                begin
                    ey_next = ey_m1;
                    py_next = py_dec;
                    d_next  = d_reg + ((b2_d - py_dec_d + px_inc_d) <<< 2);
                end
            end
            OP_R2_SQ1:
            begin
                mul_a = MUL_W'({ex_reg, 1'b1});
                mul_b = MUL_W'({ex_reg, 1'b1});
            end
            OP_R2_M1:
            begin
                mul_a = MUL_W'(b2_reg);
                mul_b = prod_reg[MUL_W-1:0];
            end
            OP_R2_SQ2:
            begin
                d_next = prod_d;
                mul_a  = MUL_W'(ey_m1);
                mul_b  = MUL_W'(ey_m1);
            end
            OP_R2_M2:
            begin
                mul_a = MUL_W'(a2_reg);
                mul_b = prod_reg[MUL_W-1:0];
            end
            OP_R2_M3:
            begin
                d_next = d_reg + (prod_d <<< 2);
                mul_a  = MUL_W'(a2_reg);
                mul_b  = MUL_W'(b2_reg);
            end
            OP_R2_FIN:
            begin
                d_next = d_reg - (prod_d <<< 2);
            end
            OP_STEP2:
            begin
                ey_next = ey_m1;
                py_next = py_dec;
                if (d_pos)
                begin
                    d_next = d_reg + ((a2_d - py_dec_d) <<< 2);
                end
                else
                begin
                    ex_next = ex_reg + STEP_W'(1);
                    px_next = px_inc;
                    d_next  = d_reg + ((a2_d - py_dec_d + px_inc_d) <<< 2);
                end
            end
            default: ;
        endcase
    end

    // Shared multiplier with registered product.
    assign prod_next = mul_a * mul_b;

    // Walk and payload registers.
    always_ff @(posedge clk)
    begin
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        sh_reg         <= sh_next;
        b_reg          <= b_next;
        a2_reg         <= a2_next;
        b2_reg         <= b2_next;
        ex_reg         <= ex_next;
        ey_reg         <= ey_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        d_reg          <= d_next;
        prod_reg       <= prod_next;
        x_right_reg    <= x_right_next;
        x_left_reg     <= x_left_next;
        y_upper_reg    <= y_upper_next;
        y_lower_reg    <= y_lower_next;
        last_point_reg <= last_point_next;
    end

    assign x_right    = x_right_reg;
    assign x_left     = x_left_reg;
    assign y_upper    = y_upper_reg;
    assign y_lower    = y_lower_reg;
    assign last_point = last_point_reg;

endmodule

// ----- src/mep_ctrl.sv -----
// Controller: sequences setup, region steps and result hand-off.
`include "midpoint_ellipse_points_defines.svh"

module mep_ctrl import mep_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_SQ_B    = 13'b0000000000010,
        S_A2B     = 13'b0000000000100,
        S_INIT    = 13'b0000000001000,
        S_EMIT    = 13'b0000000010000,
        S_STEP1   = 13'b0000000100000,
        S_R2_SQ1  = 13'b0000001000000,
        S_R2_M1   = 13'b0000010000000,
        S_R2_SQ2  = 13'b0000100000000,
        S_R2_M2   = 13'b0001000000000,
        S_R2_M3   = 13'b0010000000000,
        S_R2_FIN  = 13'b0100000000000,
        S_STEP2   = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              region_two_reg, region_two_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free, last_c;

    // The output register may be loaded when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // This result closes the run when the limit is hit or the walk is done.
    assign last_c = (cnt_reg == CNT_LAST) ||
                    (status.ey_zero && (region_two_reg || !status.px_lt_py));

    // Next-state and command logic.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        region_two_next = region_two_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;
        cmd.op          = OP_NONE;
        cmd.last        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op          = OP_START;
                    cnt_next        = '0;
                    region_two_next = 1'b0;
                    state_next      = S_SQ_B;
                end
            end
            S_SQ_B:
            begin
                cmd.op     = OP_SQ_B;
                state_next = S_A2B;
            end
            S_A2B:
            begin
                cmd.op     = OP_A2B;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_EMIT;
                    cmd.last       = last_c;
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg + STEP_W'(1);
                    if (last_c)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (region_two_reg)
                    begin
                        state_next = S_STEP2;
                    end
                    else if (status.px_lt_py)
                    begin
                        state_next = S_STEP1;
                    end
                    else
                    begin
                        state_next = S_R2_SQ1;
                    end
                end
            end
            S_STEP1:
            begin
                cmd.op     = OP_STEP1;
                state_next = S_EMIT;
            end
            S_R2_SQ1:
            begin
                cmd.op          = OP_R2_SQ1;
                region_two_next = 1'b1;
                state_next      = S_R2_M1;
            end
            S_R2_M1:
            begin
                cmd.op     = OP_R2_M1;
                state_next = S_R2_SQ2;
            end
            S_R2_SQ2:
            begin
                cmd.op     = OP_R2_SQ2;
                state_next = S_R2_M2;
            end
            S_R2_M2:
            begin
                cmd.op     = OP_R2_M2;
                state_next = S_R2_M3;
            end
            S_R2_M3:
            begin
                cmd.op     = OP_R2_M3;
                state_next = S_R2_FIN;
            end
            S_R2_FIN:
            begin
                cmd.op     = OP_R2_FIN;
                state_next = S_STEP2;
            end
            S_STEP2:
            begin
                cmd.op     = OP_STEP2;
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            region_two_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            region_two_reg <= region_two_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result is written only into a free output register.
    `MEP_ASSERT_NOW(a_emit_slot_free, clk, rst_n, cmd.op == OP_EMIT, slot_free, "emit into busy output register")
    // The result that reaches the limit must close the run.
    `MEP_ASSERT_NOW(a_limit_last, clk, rst_n, (cmd.op == OP_EMIT) && (cnt_reg == CNT_LAST), cmd.last, "result limit reached without last mark")
    // The closing result returns the controller to idle.
    `MEP_ASSERT_NEXT(a_last_idle, clk, rst_n, (cmd.op == OP_EMIT) && cmd.last, state_reg == S_IDLE, "run did not end after last result")
    // An accepted request starts the setup sequence.
    `MEP_ASSERT_NEXT(a_start_setup, clk, rst_n, in_valid && in_ready, state_reg == S_SQ_B, "accepted request did not start setup")
    // Output valid rises only after a result was written.
    `MEP_ASSERT_NOW(a_valid_from_emit, clk, rst_n, $rose(out_valid_reg), $past(cmd.op == OP_EMIT), "output valid without result write")

endmodule

// ----- tb/ellipse_points_checker.sv -----
// Checker that predicts the plot points of each ellipse request and compares the results.
module ellipse_points_checker import mep_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RADIUS_W-1:0]  cfg_data,
    mep_in_if                    ellipse,
    mep_out_if                   points,
    output int                   pending,
    output int                   failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_right;
        logic [COORD_BITS-1:0] x_left;
        logic [COORD_BITS-1:0] y_upper;
        logic [COORD_BITS-1:0] y_lower;
        logic                  last_point;
    } point_t;

    // Local copy of the two semi-axis registers.
    logic [RADIUS_W-1:0] semi_axis_a;
    logic [RADIUS_W-1:0] semi_axis_b;

    // Plot points still owed by the block, oldest first.
    point_t expected_points[$];

    // Saturate to the signed coordinate range and keep the low bits.
    function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            v = hi;
        end
        if (v < lo)
        begin
            v = lo;
        end
        return COORD_BITS'(v);
    endfunction

    // Queue the four mirrored points of one walk position.
    function automatic void push_point(longint cx, longint cy, longint sh,
                                       longint ex, longint ey);
        point_t p;
        p.x_right    = clamp_coord(cx + ex + sh);
        p.x_left     = clamp_coord(cx - ex + sh);
        p.y_upper    = clamp_coord(cy + ey);
        p.y_lower    = clamp_coord(cy - ey);
        p.last_point = 1'b0;
        expected_points.push_back(p);
    endfunction

    // Walk the whole ellipse for one request. The decision value is kept at four
    // times its textbook value so that the quarter and half terms stay whole.
    function automatic void trace_ellipse(logic [FIELD_W-1:0] cx_raw,
                                          logic [FIELD_W-1:0] cy_raw,
                                          logic [FIELD_W-1:0] sh_raw);
        longint cx;
        longint cy;
        longint sh;
        longint a2;
        longint b2;
        longint ex;
        longint ey;
        longint gx;
        longint gy;
        longint dec;
        int     n;
        cx  = longint'($signed(cx_raw));
        cy  = longint'($signed(cy_raw));
        sh  = longint'(sh_raw);
        a2  = longint'(semi_axis_a) * longint'(semi_axis_a);
        b2  = longint'(semi_axis_b) * longint'(semi_axis_b);
        ex  = 0;
        ey  = longint'(semi_axis_b);
        gx  = 0;
        gy  = 2 * a2 * ey;
        dec = 4 * b2 - 4 * a2 * ey + a2;
        n   = 1;
        push_point(cx, cy, sh, ex, ey);

        // Region one: x steps every time while the slope is shallow.
        while (gx < gy && n < MAX_RESULTS)
        begin
            ex++;
            gx += 2 * b2;
            if (dec < 0)
            begin
                dec += 4 * (b2 + gx);
            end
            else
            begin
                ey--;
                gy -= 2 * a2;
                dec += 4 * (b2 - gy + gx);
            end
            push_point(cx, cy, sh, ex, ey);
            n++;
        end

        // Region two: y steps every time until the axis is reached.
        dec = b2 * (2 * ex + 1) * (2 * ex + 1) + 4 * a2 * (ey - 1) * (ey - 1) - 4 * a2 * b2;
        while (ey > 0 && n < MAX_RESULTS)
        begin
            ey--;
            gy -= 2 * a2;
            if (dec > 0)
            begin
                dec += 4 * (a2 - gy);
            end
            else
            begin
                ex++;
                gx += 2 * b2;
                dec += 4 * (a2 - gy + gx);
            end
            push_point(cx, cy, sh, ex, ey);
            n++;
        end

        expected_points[expected_points.size() - 1].last_point = 1'b1;
    endfunction

    // Compare one field and report it on mismatch.
    function automatic int match_field(string field, logic [COORD_BITS-1:0] want,
                                       logic [COORD_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, $signed(want), $signed(got));
            return 1;
        end
        return 0;
    endfunction

    // Track configuration, requests and results at every clock edge.
    always @(posedge clk or negedge rst_n)
    begin : track
        point_t want;
        if (!rst_n)
        begin
            expected_points.delete();
            semi_axis_a = RADIUS_X_RESET;
            semi_axis_b = RADIUS_Y_RESET;
            failures    = 0;
            pending    <= 0;
        end
        else
        begin
            // Results are checked before a request taken at the same edge is queued.
            if (points.valid && points.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result: x_right %0d x_left %0d y_upper %0d y_lower %0d",
                           $signed(points.x_right), $signed(points.x_left),
                           $signed(points.y_upper), $signed(points.y_lower));
                    failures++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    failures += match_field("x_right", want.x_right, points.x_right);
                    failures += match_field("x_left", want.x_left, points.x_left);
                    failures += match_field("y_upper", want.y_upper, points.y_upper);
                    failures += match_field("y_lower", want.y_lower, points.y_lower);
                    failures += match_field("last_point", COORD_BITS'(want.last_point),
                                            COORD_BITS'(points.last_point));
                end
            end
            if (ellipse.valid && ellipse.ready)
            begin
                trace_ellipse(ellipse.center_x, ellipse.center_y, ellipse.shift_x);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RADIUS_X: semi_axis_a = cfg_data;
                    CFG_RADIUS_Y: semi_axis_b = cfg_data;
                    default: ;
                endcase
            end
            pending <= expected_points.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the ellipse point generator testbench: clock, reset, stimulus and verdict.
module testbench import mep_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = COORD_BITS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 150;
    localparam int RANDOM_GROUPS  = 10;
    localparam int GROUP_ITEMS    = 20;
    localparam int HOLD_GROUP     = 3;

    typedef enum int {
        SINK_FREE,
        SINK_MOSTLY,
        SINK_COIN,
        SINK_PERIODIC
    } sink_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RADIUS_W-1:0]  cfg_data;
    int                   pending;
    int                   failures;
    int                   hold_requests = 0;
    int                   quiet_cycles = 0;
    int                   burst_left = 0;
    bit                   offering = 1'b0;

    mep_in_if ellipse_ch ();
    mep_out_if #(.COORD_BITS(COORD_BITS)) points_ch ();

    midpoint_ellipse_points #(.COORD_BITS(COORD_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ellipse   (ellipse_ch),
        .points    (points_ch)
    );

    ellipse_points_checker #(.COORD_BITS(COORD_BITS)) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ellipse   (ellipse_ch),
        .points    (points_ch),
        .pending   (pending),
        .failures  (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one request and wait for it; bursts end in a gap of random length.
    task automatic offer_ellipse(int cx, int cy, int sh);
        int gap;
        ellipse_ch.valid    <= 1'b1;
        ellipse_ch.center_x <= FIELD_W'(cx);
        ellipse_ch.center_y <= FIELD_W'(cy);
        ellipse_ch.shift_x  <= FIELD_W'(sh);
        offering = 1'b1;
        @(posedge clk);
        while (!ellipse_ch.ready)
        begin
            @(posedge clk);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 5);
            ellipse_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every owed result has been taken.
    task automatic wait_drained();
        if (offering)
        begin
            ellipse_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge clk); while (pending != 0);
    endtask

    // Write both semi-axes back to back, radius_x first, while the block is idle.
    task automatic set_radii(int ax, int by);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RADIUS_X;
        cfg_data  <= RADIUS_W'(ax);
        @(posedge clk);
        cfg_index <= CFG_RADIUS_Y;
        cfg_data  <= RADIUS_W'(by);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Raw field bits, weighted toward the extremes of the signed and unsigned ranges.
    function automatic int pick_field();
        case ($urandom_range(0, 7))
            0: return 'h200;
            1: return 'h1FF;
            2: return 0;
            3: return 'h3FF;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic int pick_radius();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 31;
            2: return 1;
            default: return $urandom_range(1, 31);
        endcase
    endfunction

    // Main stimulus sequence.
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_RADIUS_X;
        cfg_data            = '0;
        ellipse_ch.valid    = 1'b0;
        ellipse_ch.center_x = '0;
        ellipse_ch.center_y = '0;
        ellipse_ch.shift_x  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Radii from reset, with field extremes and saturation in both directions.
        offer_ellipse(0, 0, 0);
        offer_ellipse(511, 511, 1023);
        offer_ellipse(-512, -512, 0);
        offer_ellipse(-512, 511, 1023);
        offer_ellipse(511, -512, 0);
        offer_ellipse('h155, 'h2AA, 'h2AA);
        offer_ellipse('h2AA, 'h155, 'h155);

        // Largest ellipse.
        set_radii(31, 31);
        offer_ellipse(511, 511, 1023);
        offer_ellipse(-512, -512, 0);
        offer_ellipse(0, 0, 512);

        // Smallest nonzero ellipse.
        set_radii(1, 1);
        offer_ellipse(-1, 1, 1);
        offer_ellipse(511, -512, 1023);

        // Zero horizontal radius walks straight down; zero vertical radius is one point.
        set_radii(0, 9);
        offer_ellipse(100, -100, 7);
        set_radii(9, 0);
        offer_ellipse(-100, 100, 900);
        set_radii(0, 0);
        offer_ellipse(511, -512, 1023);

        // Very flat and very tall ellipses.
        set_radii(31, 1);
        offer_ellipse(-300, 200, 300);
        set_radii(1, 31);
        offer_ellipse(300, -200, 50);

        // Random requests in groups, each with its own pair of radii.
        for (int g = 0; g < RANDOM_GROUPS; g++)
        begin
            set_radii(pick_radius(), pick_radius());
            for (int i = 0; i < GROUP_ITEMS; i++)
            begin
                if (g == HOLD_GROUP && i == 0)
                begin
                    hold_requests++;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    wait_drained();
                end
                offer_ellipse(pick_field(), pick_field(), pick_field());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("[midpoint_ellipse_points] OK");
        end
        else
        begin
            $display("[midpoint_ellipse_points] ERROR");
        end
        $finish;
    end

    // Result side: stall patterns change every stretch; a long hold-off on request.
    initial
    begin : result_sink
        sink_mode_t mode;
        int         span;
        int         stall_left;
        int         served;
        int         phase;
        points_ch.ready = 1'b0;
        mode       = SINK_FREE;
        span       = 0;
        stall_left = 0;
        served     = 0;
        phase      = 0;
        forever
        begin
            @(posedge clk);
            if (served != hold_requests)
            begin
                served     = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (span == 0)
            begin
                mode = sink_mode_t'($urandom_range(0, 3));
                span = $urandom_range(16, 160);
            end
            span--;
            phase = (phase + 1) % 7;
            if (stall_left > 0)
            begin
                stall_left--;
                points_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_FREE:     points_ch.ready <= 1'b1;
                    SINK_MOSTLY:   points_ch.ready <= ($urandom_range(0, 3) != 0);
                    SINK_COIN:     points_ch.ready <= ($urandom_range(0, 1) == 1);
                    SINK_PERIODIC: points_ch.ready <= (phase < 3);
                    default:       points_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog: too many cycles with no request or result taken ends the run.
    always @(posedge clk)
    begin
        if ((ellipse_ch.valid && ellipse_ch.ready) || (points_ch.valid && points_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[midpoint_ellipse_points] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
